// ----- sv/pfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, command, mode and status codes for the format checker.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int MAX_ARGS = 16;
    localparam int CNT_W    = $clog2(MAX_ARGS + 1);
    localparam int IDX_W    = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 3;
    localparam int CH_W     = 8;
    localparam int STATUS_W = 4;
    localparam int FIELD_W  = 5;
    localparam int MODE_W   = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_ARG  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

    // argument types
    localparam logic [TYPE_W-1:0] ARG_INT   = 3'd0;
    localparam logic [TYPE_W-1:0] ARG_FLOAT = 3'd1;
    localparam logic [TYPE_W-1:0] ARG_CHAR  = 3'd2;
    localparam logic [TYPE_W-1:0] ARG_STR   = 3'd3;
    localparam logic [TYPE_W-1:0] ARG_PTR   = 3'd4;

    // scan modes
    localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PCT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONV  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LONG  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_EXP_INT   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EXP_FLOAT = 4'd3;
    localparam logic [STATUS_W-1:0] ST_EXP_CHAR  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_EXP_STR   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EXP_PTR   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_LONG  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 4'd9;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 4'd10;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 4'd11;

    // format characters
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PCT   = 8'h25;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UE    = 8'h45;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_UG    = 8'h47;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_A     = 8'h61;
    localparam logic [CH_W-1:0] CH_C     = 8'h63;
    localparam logic [CH_W-1:0] CH_D     = 8'h64;
    localparam logic [CH_W-1:0] CH_E     = 8'h65;
    localparam logic [CH_W-1:0] CH_F     = 8'h66;
    localparam logic [CH_W-1:0] CH_G     = 8'h67;
    localparam logic [CH_W-1:0] CH_I     = 8'h69;
    localparam logic [CH_W-1:0] CH_L     = 8'h6C;
    localparam logic [CH_W-1:0] CH_O     = 8'h6F;
    localparam logic [CH_W-1:0] CH_P     = 8'h70;
    localparam logic [CH_W-1:0] CH_S     = 8'h73;
    localparam logic [CH_W-1:0] CH_U     = 8'h75;
    localparam logic [CH_W-1:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TYPE_W-1:0] arg_type;
        logic [CH_W-1:0]   ch;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  position;
        logic [FIELD_W-1:0]  args_used;
    } result_t;

    function automatic logic is_int_letter(input logic [CH_W-1:0] c);
        return (c == CH_D) || (c == CH_I) || (c == CH_U) || (c == CH_O) ||
               (c == CH_X) || (c == CH_UX);
    endfunction

    function automatic logic is_float_letter(input logic [CH_W-1:0] c);
        return (c == CH_F) || (c == CH_UF) || (c == CH_E) || (c == CH_UE) ||
               (c == CH_G) || (c == CH_UG) || (c == CH_A) || (c == CH_UA);
    endfunction

    function automatic logic is_flag(input logic [CH_W-1:0] c);
        return (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS) ||
               ((c >= CH_0) && (c <= CH_9));
    endfunction

endpackage

// ----- sv/printf_format_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_format_checker
// Checks a printf-style format string against loaded argument types.
// ----------------------------------------------------------------------------
// Words are argument types (cmd 0), format bytes (cmd 1) or an end marker
// (cmd 2); the block takes one word per cycle. Each word is decoded from the
// input register when the scan stage takes it, updating the scan state and
// the type store, and an end word's result is then written to the result
// register. Input stalls only when an end word is ready while the previous
// result is still waiting on m_ready. Up to MAX_ARGS (16) types may be
// loaded; the end word clears the counters and the scan and error state.
module printf_format_checker import pfc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [TYPE_W-1:0]   s_arg_type,
    input  logic [CH_W-1:0]     s_ch,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FIELD_W-1:0]  m_position,
    output logic [FIELD_W-1:0]  m_args_used
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    pop;
    logic    out_free;
    result_t result;

    logic    m_valid_reg;
    result_t m_result_reg;

    assign in_item.cmd      = s_cmd;
    assign in_item.arg_type = s_arg_type;
    assign in_item.ch       = s_ch;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = item_valid && ((item.cmd != CMD_END) || out_free);

    pfc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    pfc_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (pop),
        .item    (item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && item.cmd == CMD_END) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.cmd == CMD_END) begin
            m_result_reg <= result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_result_reg.status;
    assign m_position  = m_result_reg.position;
    assign m_args_used = m_result_reg.args_used;

endmodule

// ----- sv/pfc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_in_stage
// Input word register; holds one word until the scan stage takes it.
// ----------------------------------------------------------------------------
module pfc_in_stage import pfc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  pop,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- sv/pfc_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_scan
// Type store, counters and scan state; decodes one word per cycle while step is high.
// ----------------------------------------------------------------------------
module pfc_scan import pfc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [TYPE_W-1:0]   type_store [MAX_ARGS];
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    consumed_reg, consumed_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [FIELD_W-1:0]  pos_reg, pos_next;

    logic                do_take;
    logic [TYPE_W-1:0]   want;
    logic [STATUS_W-1:0] want_code;
    logic [STATUS_W-1:0] lcode;
    logic [TYPE_W-1:0]   head_type;
    logic [FIELD_W-1:0]  next_pos;
    logic                store_wr;
    logic                have_arg;

    assign head_type = type_store[consumed_reg[IDX_W-1:0]];
    assign next_pos  = FIELD_W'({1'b0, consumed_reg} + 1'b1);
    assign have_arg  = consumed_reg < loaded_reg;
    assign store_wr  = step && (item.cmd == CMD_ARG) && (loaded_reg < CNT_W'(MAX_ARGS));

    always_comb begin
        loaded_next   = loaded_reg;
        consumed_next = consumed_reg;
        mode_next     = mode_reg;
        err_next      = err_reg;
        pos_next      = pos_reg;
        do_take       = 1'b0;
        want          = ARG_INT;
        want_code     = ST_EXP_INT;
        lcode         = ST_OK;

        case (item.cmd)
            CMD_ARG: begin
                if (loaded_reg < CNT_W'(MAX_ARGS)) begin
                    loaded_next = loaded_reg + 1'b1;
                end else if (err_reg == ST_OK) begin
                    err_next = ST_OVERFLOW;
                    pos_next = next_pos;
                end
            end
            CMD_CHAR: begin
                if (err_reg == ST_OK) begin
                    if (mode_reg == MODE_PLAIN) begin
                        if (item.ch == CH_PCT) begin
                            mode_next = MODE_PCT;
                        end
                    end else if (mode_reg == MODE_PCT && item.ch == CH_PCT) begin
                        mode_next = MODE_PLAIN;
                    end else if (mode_reg == MODE_PCT && !have_arg) begin
                        lcode = ST_TOO_FEW;
                    end else if (mode_reg == MODE_LONG) begin
                        if (item.ch == CH_L) begin
                            mode_next = MODE_LONG;
                        end else if (is_int_letter(item.ch)) begin
                            do_take = 1'b1;
                        end else begin
                            lcode = ST_BAD_LONG;
                        end
                    end else if (is_flag(item.ch)) begin
                        mode_next = MODE_CONV;
                    end else if (item.ch == CH_L) begin
                        mode_next = MODE_LONG;
                    end else if (item.ch == CH_PCT) begin
                        mode_next = MODE_PLAIN;
                    end else if (item.ch == CH_NUL) begin
                        lcode = ST_MISSING;
                    end else if (is_int_letter(item.ch)) begin
                        do_take = 1'b1;
                    end else if (is_float_letter(item.ch)) begin
                        do_take   = 1'b1;
                        want      = ARG_FLOAT;
                        want_code = ST_EXP_FLOAT;
                    end else if (item.ch == CH_C) begin
                        do_take   = 1'b1;
                        want      = ARG_CHAR;
                        want_code = ST_EXP_CHAR;
                    end else if (item.ch == CH_S) begin
                        do_take   = 1'b1;
                        want      = ARG_STR;
                        want_code = ST_EXP_STR;
                    end else if (item.ch == CH_P) begin
                        do_take   = 1'b1;
                        want      = ARG_PTR;
                        want_code = ST_EXP_PTR;
                    end else begin
                        lcode = ST_INVALID;
                    end
                    if (do_take) begin
                        if (have_arg && head_type == want) begin
                            consumed_next = consumed_reg + 1'b1;
                            mode_next     = MODE_PLAIN;
                        end else begin
                            lcode = want_code;
                        end
                    end
                    if (lcode != ST_OK) begin
                        err_next  = lcode;
                        pos_next  = next_pos;
                        mode_next = MODE_PLAIN;
                    end
                end
            end
            CMD_END: begin
                if (err_reg == ST_OK) begin
                    if (mode_reg == MODE_PCT && !have_arg) begin
                        lcode = ST_TOO_FEW;
                    end else if (mode_reg == MODE_PCT || mode_reg == MODE_CONV) begin
                        lcode = ST_MISSING;
                    end else if (mode_reg == MODE_LONG) begin
                        lcode = ST_BAD_LONG;
                    end else if (have_arg) begin
                        lcode = ST_TOO_MANY;
                    end
                end
                loaded_next   = '0;
                consumed_next = '0;
                mode_next     = MODE_PLAIN;
                err_next      = ST_OK;
                pos_next      = '0;
            end
            default: begin
            end
        endcase
    end

    // result for an end word, with any error found at the end folded in
    always_comb begin
        result.args_used = FIELD_W'(consumed_reg);
        if (err_reg != ST_OK) begin
            result.status   = err_reg;
            result.position = pos_reg;
        end else if (lcode != ST_OK) begin
            result.status   = lcode;
            result.position = next_pos;
        end else begin
            result.status   = ST_OK;
            result.position = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg   <= '0;
            consumed_reg <= '0;
            mode_reg     <= MODE_PLAIN;
            err_reg      <= ST_OK;
            pos_reg      <= '0;
        end else if (step) begin
            loaded_reg   <= loaded_next;
            consumed_reg <= consumed_next;
            mode_reg     <= mode_next;
            err_reg      <= err_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            type_store[loaded_reg[IDX_W-1:0]] <= item.arg_type;
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for printf_format_checker.
// ----------------------------------------------------------------------------
// Argument types, format bytes and end words go in on the s_ channel. An
// in-bench scoreboard keeps its own copy of the scan state and the type list
// and predicts the status word for every end word. Each m_ word is then
// compared field by field with the oldest prediction. The run has directed
// corner cases, full and overflowing argument lists, random format strings
// (mostly well formed, some broken), and one long output stall that backs
// up the input. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import pfc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 700;
    localparam int LONG_HOLD      = 300;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd      = CMD_ARG;
    logic [TYPE_W-1:0]   s_arg_type = ARG_INT;
    logic [CH_W-1:0]     s_ch       = CH_NUL;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [FIELD_W-1:0]  m_position;
    logic [FIELD_W-1:0]  m_args_used;

    // scoreboard copy of the checker state
    logic [TYPE_W-1:0]   arg_types [MAX_ARGS];
    logic [FIELD_W-1:0]  n_loaded;
    logic [FIELD_W-1:0]  n_used;
    logic [FIELD_W-1:0]  err_pos;
    logic [MODE_W-1:0]   scan;
    logic [STATUS_W-1:0] err;
    result_t             pending_results [$];

    int words_sent      = 0;
    int strings_sent    = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int burst_left      = 0;
    int hold_req        = 0;
    bit no_gaps         = 1'b0;

    printf_format_checker u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_arg_type  (s_arg_type),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_position  (m_position),
        .m_args_used (m_args_used)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // format scoreboard
    // ------------------------------------------------------------------
    function automatic void clear_scan_state();
        n_loaded = '0;
        n_used   = '0;
        err_pos  = '0;
        scan     = MODE_PLAIN;
        err      = ST_OK;
    endfunction

    function automatic void flag_error(input logic [STATUS_W-1:0] code);
        if (err == ST_OK) begin
            err     = code;
            err_pos = n_used + 1'b1;
        end
        scan = MODE_PLAIN;
    endfunction

    function automatic void consume(input logic [TYPE_W-1:0] want,
                                    input logic [STATUS_W-1:0] code);
        if (n_used < n_loaded && arg_types[n_used[IDX_W-1:0]] == want) begin
            n_used = n_used + 1'b1;
            scan   = MODE_PLAIN;
        end else begin
            flag_error(code);
        end
    endfunction

    function automatic logic conv_target(input logic [CH_W-1:0] c,
                                         output logic [TYPE_W-1:0] want,
                                         output logic [STATUS_W-1:0] code);
        want = ARG_INT;
        code = ST_EXP_INT;
        case (c)
            CH_D, CH_I, CH_U, CH_O, CH_X, CH_UX: return 1'b1;
            CH_F, CH_UF, CH_E, CH_UE, CH_G, CH_UG, CH_A, CH_UA: begin
                want = ARG_FLOAT;
                code = ST_EXP_FLOAT;
                return 1'b1;
            end
            CH_C: begin
                want = ARG_CHAR;
                code = ST_EXP_CHAR;
                return 1'b1;
            end
            CH_S: begin
                want = ARG_STR;
                code = ST_EXP_STR;
                return 1'b1;
            end
            CH_P: begin
                want = ARG_PTR;
                code = ST_EXP_PTR;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void load_type(input logic [TYPE_W-1:0] t);
        if (n_loaded < MAX_ARGS) begin
            arg_types[n_loaded[IDX_W-1:0]] = t;
            n_loaded = n_loaded + 1'b1;
        end else if (err == ST_OK) begin
            err     = ST_OVERFLOW;
            err_pos = n_used + 1'b1;
        end
    endfunction

    function automatic void scan_byte(input logic [CH_W-1:0] c);
        logic [TYPE_W-1:0]   want;
        logic [STATUS_W-1:0] code;
        logic                known;
        if (err != ST_OK)
            return;
        if (scan == MODE_PLAIN) begin
            if (c == CH_PCT)
                scan = MODE_PCT;
            return;
        end
        if (scan == MODE_PCT) begin
            if (c == CH_PCT) begin
                scan = MODE_PLAIN;
                return;
            end
            if (n_used >= n_loaded) begin
                flag_error(ST_TOO_FEW);
                return;
            end
        end
        known = conv_target(c, want, code);
        if (scan == MODE_LONG) begin
            if (c == CH_L)
                return;
            if (known && want == ARG_INT)
                consume(want, code);
            else
                flag_error(ST_BAD_LONG);
            return;
        end
        if (c == CH_DOT || c == CH_MINUS || c == CH_PLUS || (c >= CH_0 && c <= CH_9))
            scan = MODE_CONV;
        else if (c == CH_L)
            scan = MODE_LONG;
        else if (c == CH_PCT)
            scan = MODE_PLAIN;
        else if (c == CH_NUL)
            flag_error(ST_MISSING);
        else if (known)
            consume(want, code);
        else
            flag_error(ST_INVALID);
    endfunction

    function automatic void close_string();
        result_t r;
        if (err == ST_OK) begin
            if (scan == MODE_PCT && n_used >= n_loaded)
                flag_error(ST_TOO_FEW);
            else if (scan == MODE_PCT || scan == MODE_CONV)
                flag_error(ST_MISSING);
            else if (scan == MODE_LONG)
                flag_error(ST_BAD_LONG);
            else if (n_used < n_loaded)
                flag_error(ST_TOO_MANY);
        end
        r.status    = err;
        r.position  = (err != ST_OK) ? err_pos : '0;
        r.args_used = n_used;
        pending_results.push_back(r);
        clear_scan_state();
    endfunction

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TYPE_W-1:0] t,
                             input logic [CH_W-1:0] c);
        int gap;
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_arg_type <= t;
        s_ch       <= c;
        do @(posedge aclk); while (!s_ready);
        case (cmd)
            CMD_ARG:  load_type(t);
            CMD_CHAR: scan_byte(c);
            CMD_END: begin
                close_string();
                strings_sent++;
            end
            default: ;
        endcase
        if (cmd != CMD_UNUSED)
            words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic give_type(input logic [TYPE_W-1:0] t);
        send_word(CMD_ARG, t, CH_W'($urandom_range(0, 255)));
    endtask

    task automatic give_char(input logic [CH_W-1:0] c);
        send_word(CMD_CHAR, TYPE_W'($urandom_range(0, 7)), c);
    endtask

    task automatic give_text(input string s);
        for (int i = 0; i < s.len(); i++)
            give_char(s[i]);
    endtask

    task automatic give_end();
        send_word(CMD_END, TYPE_W'($urandom_range(0, 7)), CH_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [CH_W-1:0] letter_for(input logic [TYPE_W-1:0] t);
        case (t)
            ARG_INT: begin
                case ($urandom_range(0, 5))
                    0: return CH_D;
                    1: return CH_I;
                    2: return CH_U;
                    3: return CH_O;
                    4: return CH_X;
                    default: return CH_UX;
                endcase
            end
            ARG_FLOAT: begin
                case ($urandom_range(0, 7))
                    0: return CH_F;
                    1: return CH_UF;
                    2: return CH_E;
                    3: return CH_UE;
                    4: return CH_G;
                    5: return CH_UG;
                    6: return CH_A;
                    default: return CH_UA;
                endcase
            end
            ARG_CHAR: return CH_C;
            ARG_STR:  return CH_S;
            ARG_PTR:  return CH_P;
            default:  return letter_for(TYPE_W'($urandom_range(0, 4)));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] flag_byte();
        case ($urandom_range(0, 3))
            0: return CH_DOT;
            1: return CH_MINUS;
            2: return CH_PLUS;
            default: return CH_0 + CH_W'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] text_byte();
        logic [CH_W-1:0] c;
        do c = CH_W'($urandom_range(0, 255)); while (c == CH_PCT);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_special_cases();
        give_end();
        // too few args, caught at the end word
        give_text("%");
        give_end();
        send_word(CMD_UNUSED, TYPE_W'(7), 8'hFF);
        // ignored bytes in plain text, late load, percent literal, bad type
        give_char(CH_NUL);
        give_char(8'hFF);
        give_type(3'd7);
        give_text("%%%d");
        give_end();
        // nul after l, then later bytes ignored
        give_type(ARG_FLOAT);
        give_text("%l");
        give_char(CH_NUL);
        give_text("f");
        give_end();
        give_type(ARG_INT);
        give_char(CH_PCT);
        give_char(CH_NUL);
        give_end();
        give_type(ARG_STR);
        give_text("%-9.l");
        give_end();
        give_text("%x");
        give_end();
        give_type(ARG_PTR);
        give_type(ARG_CHAR);
        give_text("%p%");
        give_char(8'hFF);
        give_end();
        wait_drained();
    endtask

    task automatic test_argument_limits();
        repeat (MAX_ARGS) give_type(ARG_INT);
        repeat (MAX_ARGS) give_text("%i");
        give_end();
        repeat (MAX_ARGS) give_type(ARG_FLOAT);
        repeat (MAX_ARGS) give_text("%+e");
        give_type(ARG_PTR);
        give_end();
        for (int i = 0; i <= MAX_ARGS; i++)
            give_type(TYPE_W'(i));
        give_text("%d");
        give_end();
        wait_drained();
    endtask

    task automatic test_random_strings(input int target);
        logic [TYPE_W-1:0] types [MAX_ARGS + 2];
        int stop_at;
        int n_args;
        int early;
        int noise_at;
        int r;
        stop_at = words_sent + target;
        while (words_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                n_args = $urandom_range(0, 3);
            else if (r < 92)
                n_args = $urandom_range(4, 9);
            else if (r < 98)
                n_args = $urandom_range(10, MAX_ARGS);
            else
                n_args = $urandom_range(MAX_ARGS + 1, MAX_ARGS + 2);
            for (int i = 0; i < n_args; i++)
                types[i] = ($urandom_range(0, 99) < 95) ? TYPE_W'($urandom_range(0, 4))
                                                        : TYPE_W'($urandom_range(5, 7));
            early    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_args) : n_args;
            noise_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_args) : -1;
            for (int i = 0; i < early; i++)
                give_type(types[i]);
            for (int i = 0; i <= n_args; i++) begin
                if (i == noise_at) begin
                    case ($urandom_range(0, 5))
                        0: give_char(CH_W'($urandom_range(0, 255)));
                        1: send_word(CMD_UNUSED, TYPE_W'($urandom_range(0, 7)),
                                     CH_W'($urandom_range(0, 255)));
                        2: give_text("%d");
                        3: begin
                            give_char(CH_PCT);
                            give_char(CH_NUL);
                        end
                        4: give_type(TYPE_W'($urandom_range(0, 7)));
                        default: give_char(CH_PCT);
                    endcase
                end
                if (i == n_args)
                    break;
                if (i >= early)
                    give_type(types[i]);
                repeat ($urandom_range(0, 2)) give_char(text_byte());
                if ($urandom_range(0, 9) == 0)
                    give_text("%%");
                give_char(CH_PCT);
                repeat ($urandom_range(0, 2)) give_char(flag_byte());
                r = $urandom_range(0, 99);
                if ((types[i] == ARG_INT && r < 25) || r < 3)
                    repeat ($urandom_range(1, 2)) give_char(CH_L);
                if ($urandom_range(0, 99) < 95)
                    give_char(letter_for(types[i]));
                else
                    give_char(letter_for(TYPE_W'($urandom_range(0, 4))));
            end
            repeat ($urandom_range(0, 2)) give_char(text_byte());
            give_end();
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_req = LONG_HOLD;
        while (hold_req != 0)
            @(posedge aclk);
        no_gaps = 1'b1;
        repeat (60) begin
            give_type(ARG_PTR);
            give_text("%p");
            give_end();
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    initial begin
        int hold_len;
        int r;
        forever begin
            if (hold_req > 0) begin
                hold_len = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (r < 70) begin
                    m_ready <= 1'b1;
                    repeat (40) @(posedge aclk);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d position %0d args_used %0d",
                             m_status, m_position, m_args_used);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_position !== want.position ||
                    m_args_used !== want.args_used) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on word %0d: status %0d/%0d position %0d/%0d %s",
                                 results_checked, want.status, m_status, want.position,
                                 m_position, $sformatf("args_used %0d/%0d (exp/got)",
                                 want.args_used, m_args_used));
                end
            end
        end
    end

    // watchdog on handshake activity
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("printf_format_checker regression: fail");
        $finish;
    end

    initial begin
        clear_scan_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_argument_limits();
        test_random_strings(RANDOM_WORDS);
        test_output_stall();
        test_random_strings(RANDOM_WORDS);
        wait_drained();
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected words never arrived", pending_results.size());
        end
        $display("sent %0d words in %0d format strings, checked %0d status words",
                 words_sent, strings_sent, results_checked);
        $display("corner cases, full and overflowing arg lists, random strings, long stall");
        if (mismatches == 0)
            $display("printf_format_checker regression: pass");
        else
            $display("printf_format_checker regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pfc_pkg.sv
sv/pfc_in_stage.sv
sv/pfc_scan.sv
sv/printf_format_checker.sv
test/testbench.sv
